@@ hdl/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    // Bus access commands
    localparam logic [1:0] CMD_CPU_RD = 2'd0;
    localparam logic [1:0] CMD_CPU_WR = 2'd1;
    localparam logic [1:0] CMD_PPU_RD = 2'd2;
    localparam logic [1:0] CMD_PPU_WR = 2'd3;

    // Result targets
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_REG  = 3'd1;
    localparam logic [2:0] TGT_RAM  = 3'd2;
    localparam logic [2:0] TGT_PRG  = 3'd3;
    localparam logic [2:0] TGT_CHR  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_ROM_SIZE = 2'd0;
    localparam logic [1:0] CFG_CHR_ROM_SIZE = 2'd1;
    localparam logic [1:0] CFG_PRG_RAM_SIZE = 2'd2;

    localparam int CFG_DATA_W = 24;

    // Register addresses and values with special handling
    localparam logic [15:0] ADDR_TRIGGER   = 16'h5101;
    localparam logic [15:0] ADDR_LATCH1    = 16'h5100;
    localparam logic [7:0]  PRG_FORCE_CODE = 8'd6;
    localparam logic [7:0]  PRG_FORCE_BANK = 8'd3;
    localparam logic [7:0]  RD_DEFAULT     = 8'd4;

    // Video timing points for the pattern bank switching
    localparam logic [8:0] LINE_SPLIT_LO = 9'd127;
    localparam logic [8:0] LINE_SPLIT_HI = 9'd239;
    localparam logic [8:0] LINE_LIMIT    = 9'd128;
    localparam logic [8:0] DOT_LIMIT     = 9'd256;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  write_value;
        logic [8:0]  scanline;
        logic [8:0]  dot;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [22:0] mem_address;
        logic [7:0]  data;
        logic        mem_write;
    } rsp_t;

endpackage

@@ hdl/cbm_mod.sv @@
// Restoring remainder unit: 8-bit bank number modulo a 9-bit bank count, one bit a cycle.
module cbm_mod (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [8:0] divisor,
    output logic       done,
    output logic [8:0] remainder
);
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [8:0] rem_reg, rem_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [8:0] dvs_reg, dvs_next;
    logic [9:0] trial;

    assign trial = {rem_reg, dvd_reg[7]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd8;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per step; remainder always stays below the divisor
            if (trial >= {1'b0, dvs_reg})
                rem_next = 9'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[8:0];
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/cartridge_bank_mapper_top.sv @@
// Top level of the cartridge bank mapper: register file, access decode and sequencer.
//
// Usage:
//   req/req_valid/req_ready carries one CPU or PPU bus access per transaction,
//   with the current scanline and dot. rsp/rsp_valid/rsp_ready returns exactly
//   one translated result per access: target memory, byte address, data and
//   write strobe. cfg_we/cfg_index/cfg_wdata writes the three size registers
//   (program ROM, pattern memory, work RAM); write them only while idle.
// Sequencing:
//   Register, work RAM and pattern results pass from the holding register to
//   the output register. Program ROM reads first take the bank number modulo
//   the bank count in the remainder unit, one bit per cycle, 8 steps. One
//   access is in work at a time; req_ready returns with the load of the output
//   register.
// Reset:
//   rst_n (async, active low) empties the pipeline, restores the default sizes
//   (32 KiB program ROM, 8 KiB pattern memory, 8 KiB work RAM), clears the
//   latches, trigger, banks and auto-switch, and sets the toggle.
// Stall:
//   A finished result waits in a holding register while rsp is stalled; the
//   output register keeps its transaction until rsp_ready.
module cartridge_bank_mapper_top #(
    parameter logic [23:0] PRG_ROM_RESET = 24'd32768,
    parameter logic [20:0] CHR_ROM_RESET = 21'd8192,
    parameter logic [13:0] PRG_RAM_RESET = 14'd8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  cbm_pkg::req_t        req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output cbm_pkg::rsp_t        rsp
);
    import cbm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    // Configuration
    logic [23:0] prg_size_reg;
    logic [20:0] chr_size_reg;
    logic [13:0] ram_size_reg;

    // Mapper state
    logic [7:0] latch_reg [4];
    logic [7:0] latch_next [4];
    logic [7:0] trigger_reg, trigger_next;
    logic       toggle_reg, toggle_next;
    logic [7:0] prg_bank_reg, prg_bank_next;
    logic       chr_lo_reg, chr_lo_next;
    logic       chr_hi_reg, chr_hi_next;
    logic       auto_reg, auto_next;

    // Sequencer
    state_t      state_reg, state_next;
    rsp_t        res_reg, res_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [14:0] prg_off_reg, prg_off_next;

    logic        accept;
    logic        is_cpu, is_wr;
    logic        in_ram, in_regs, in_rom;
    logic        div_start, div_done;
    logic [8:0]  div_rem;
    logic [8:0]  prg_banks;
    logic [8:0]  chr_banks;
    logic [7:0]  rd_value;
    logic        chr_bank, chr_eff;
    logic [12:0] chr_addr;
    logic [23:0] prg_addr;
    rsp_t        quick_res;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign is_cpu    = (req.cmd == CMD_CPU_RD) || (req.cmd == CMD_CPU_WR);
    assign is_wr     = (req.cmd == CMD_CPU_WR) || (req.cmd == CMD_PPU_WR);
    assign in_ram    = (req.address[15:13] == 3'b011);
    assign in_regs   = (req.address[15:12] == 4'h5);
    assign in_rom    = req.address[15];

    // Bank counts; a program bank count of zero acts as one
    assign prg_banks = (prg_size_reg[23:15] == 9'd0) ? 9'd1 : prg_size_reg[23:15];
    assign chr_banks = chr_size_reg[20:12];

    cbm_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prg_bank_reg),
        .divisor   (prg_banks),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Protection read values, decoded on address & 0x7700
    always_comb
    begin
        case (req.address[10:8])
            3'd1:    rd_value = latch_reg[3] | latch_reg[1] | latch_reg[0] | ~latch_reg[2];
            3'd5:    rd_value = toggle_reg ? (latch_reg[3] | latch_reg[0]) : 8'd0;
            default: rd_value = RD_DEFAULT;
        endcase
    end

    // Register writes and automatic pattern bank switching
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            latch_next[i] = latch_reg[i];
        trigger_next  = trigger_reg;
        toggle_next   = toggle_reg;
        prg_bank_next = prg_bank_reg;
        chr_lo_next   = chr_lo_reg;
        chr_hi_next   = chr_hi_reg;
        auto_next     = auto_reg;
        if (accept && req.cmd == CMD_CPU_WR && in_regs)
        begin
            if (req.address == ADDR_TRIGGER)
            begin
                // nonzero-to-zero write flips the toggle
                if (trigger_reg != 8'd0 && req.write_value == 8'd0)
                    toggle_next = ~toggle_reg;
                trigger_next = req.write_value;
            end
            else if (req.address == ADDR_LATCH1 && req.write_value == PRG_FORCE_CODE)
            begin
                prg_bank_next = PRG_FORCE_BANK;
            end
            else
            begin
                case (req.address[9:8])
                    2'd0:
                    begin
                        latch_next[0] = req.write_value;
                        if (!req.write_value[7] && req.scanline < LINE_LIMIT)
                        begin
                            chr_lo_next = 1'b0;
                            chr_hi_next = 1'b1;
                        end
                        prg_bank_next = {latch_reg[2][3:0], req.write_value[3:0]};
                        auto_next     = req.write_value[7];
                    end
                    2'd1:
                    begin
                        latch_next[1] = req.write_value;
                        if (req.write_value == PRG_FORCE_CODE)
                            prg_bank_next = PRG_FORCE_BANK;
                    end
                    2'd2:
                    begin
                        latch_next[2] = req.write_value;
                        prg_bank_next = {req.write_value[3:0], latch_reg[0][3:0]};
                        auto_next     = latch_reg[0][7];
                    end
                    default:
                    begin
                        latch_next[3] = req.write_value;
                    end
                endcase
            end
        end
        else if (accept && req.cmd == CMD_PPU_RD && auto_reg && req.dot > DOT_LIMIT)
        begin
            if (req.scanline == LINE_SPLIT_HI)
            begin
                chr_lo_next = 1'b0;
                chr_hi_next = 1'b0;
            end
            else if (req.scanline == LINE_SPLIT_LO)
            begin
                chr_lo_next = 1'b1;
                chr_hi_next = 1'b1;
            end
        end
    end

    // Pattern address; with at most two banks in play the modulo is a select
    assign chr_bank = (req.address[15:12] == 4'h0) ? chr_lo_next : chr_hi_next;
    assign chr_eff  = (chr_banks > 9'd1) ? chr_bank : 1'b0;
    assign chr_addr = {chr_eff, req.address[11:0]};

    // Results that need no iteration
    always_comb
    begin
        quick_res = '0;
        if (is_cpu)
        begin
            if (in_ram)
            begin
                if ({1'b0, req.address[12:0]} < ram_size_reg)
                begin
                    quick_res.target      = TGT_RAM;
                    quick_res.mem_address = 23'(req.address[12:0]);
                    quick_res.data        = is_wr ? req.write_value : 8'd0;
                    quick_res.mem_write   = is_wr;
                end
            end
            else if (in_regs)
            begin
                quick_res.target = TGT_REG;
                quick_res.data   = is_wr ? req.write_value : rd_value;
            end
        end
        else if (chr_size_reg != 21'd0 && {8'd0, chr_addr} < chr_size_reg)
        begin
            quick_res.target      = TGT_CHR;
            quick_res.mem_address = 23'(chr_addr);
            quick_res.data        = is_wr ? req.write_value : 8'd0;
            quick_res.mem_write   = is_wr;
        end
    end

    // Program ROM address once the bank remainder is known
    assign prg_addr = {div_rem, prg_off_reg};

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        prg_off_next   = prg_off_reg;
        div_start      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_cpu && in_rom && !in_ram && !in_regs && !is_wr)
                    begin
                        div_start    = 1'b1;
                        prg_off_next = req.address[14:0];
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        res_next   = quick_res;
                        state_next = S_HOLD;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next = '0;
                    if (prg_addr < prg_size_reg)
                    begin
                        res_next.target      = TGT_PRG;
                        res_next.mem_address = prg_addr[22:0];
                    end
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            prg_size_reg  <= PRG_ROM_RESET;
            chr_size_reg  <= CHR_ROM_RESET;
            ram_size_reg  <= PRG_RAM_RESET;
            for (int i = 0; i < 4; i++)
                latch_reg[i] <= '0;
            trigger_reg   <= '0;
            toggle_reg    <= 1'b1;
            prg_bank_reg  <= '0;
            chr_lo_reg    <= 1'b0;
            chr_hi_reg    <= 1'b0;
            auto_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_ROM_SIZE: prg_size_reg <= cfg_wdata;
                    CFG_CHR_ROM_SIZE: chr_size_reg <= cfg_wdata[20:0];
                    CFG_PRG_RAM_SIZE: ram_size_reg <= cfg_wdata[13:0];
                    default:          ;
                endcase
            end
            for (int i = 0; i < 4; i++)
                latch_reg[i] <= latch_next[i];
            trigger_reg   <= trigger_next;
            toggle_reg    <= toggle_next;
            prg_bank_reg  <= prg_bank_next;
            chr_lo_reg    <= chr_lo_next;
            chr_hi_reg    <= chr_hi_next;
            auto_reg      <= auto_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
        prg_off_reg <= prg_off_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the cartridge bank mapper: directed, size-register, random and output-stall bus traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    // Run limit in clock cycles, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 400000;

    // CPU and PPU address map
    localparam int unsigned REG_BASE     = 32'h5000;
    localparam int unsigned RAM_BASE     = 32'h6000;
    localparam int unsigned PRG_BASE     = 32'h8000;
    localparam int unsigned PPU_HI_BASE  = 32'h1000;
    localparam int unsigned PPU_OFS_MASK = 32'h0FFF;

    // Register decode: writes by address & 0x7300, reads by address & 0x7700
    localparam int unsigned WR_DECODE_MASK = 32'h7300;
    localparam int unsigned RD_DECODE_MASK = 32'h7700;
    localparam int unsigned WR_SEL_L0      = 32'h5000;
    localparam int unsigned WR_SEL_L1      = 32'h5100;
    localparam int unsigned WR_SEL_L2      = 32'h5200;
    localparam int unsigned RD_SEL_MIX     = 32'h5100;
    localparam int unsigned RD_SEL_TOGGLE  = 32'h5500;

    localparam int unsigned PRG_BANK_BYTES = 32768;
    localparam int unsigned CHR_BANK_BYTES = 4096;

    localparam int unsigned PRG_ROM_MAX = 8388608;
    localparam int unsigned CHR_ROM_MAX = 1048576;
    localparam int unsigned PRG_RAM_MAX = 8192;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_PRG_ROM_SIZE;
    logic [23:0] cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;

    cartridge_bank_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mapper state as the bench predicts it. Updated when an access is
    // accepted, so it tracks the block in acceptance order.
    // ------------------------------------------------------------------
    int unsigned prg_rom_bytes;
    int unsigned chr_bytes;
    int unsigned ram_bytes;
    logic [7:0]  latch [4];
    logic [7:0]  trigger_byte;
    logic        toggle_bit;
    logic [7:0]  prg_bank;
    logic        chr_lo;
    logic        chr_hi;
    logic        auto_sw;

    // Translated results still owed by the block, oldest first
    rsp_t        mapped_q[$];

    int unsigned tx_idle_pct = 0;     // chance the sender idles before a transaction
    int unsigned rx_idle_pct = 0;     // chance the receiver drops ready in a cycle
    int unsigned hold_cycles = 0;     // long receiver hold-off, counted down below
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Translate one bus access and advance the mapper state
    function automatic rsp_t map_access(input req_t a);
        rsp_t        r;
        logic        wr;
        logic [7:0]  v;
        int unsigned adr;
        int unsigned sel;
        int unsigned off;
        int unsigned banks;
        int unsigned bank;
        int unsigned m;
        r   = '0;
        adr = 32'(a.address);
        v   = a.write_value;
        wr  = (a.cmd == CMD_CPU_WR) || (a.cmd == CMD_PPU_WR);
        if (a.cmd == CMD_CPU_RD || a.cmd == CMD_CPU_WR)
        begin
            if (adr >= RAM_BASE && adr < PRG_BASE)
            begin
                off = adr - RAM_BASE;
                if (off < ram_bytes)
                begin
                    r.target      = TGT_RAM;
                    r.mem_address = off[22:0];
                    r.data        = wr ? v : 8'h00;
                    r.mem_write   = wr;
                end
            end
            else if (adr >= REG_BASE && adr < RAM_BASE)
            begin
                r.target = TGT_REG;
                if (!wr)
                begin
                    case (adr & RD_DECODE_MASK)
                        RD_SEL_MIX:    r.data = latch[3] | latch[1] | latch[0] | ~latch[2];
                        RD_SEL_TOGGLE: r.data = toggle_bit ? (latch[3] | latch[0]) : 8'h00;
                        default:       r.data = RD_DEFAULT;
                    endcase
                end
                else
                begin
                    r.data = v;
                    if (a.address == ADDR_TRIGGER)
                    begin
                        // nonzero followed by zero flips the toggle
                        if (trigger_byte != 8'h00 && v == 8'h00)
                            toggle_bit = ~toggle_bit;
                        trigger_byte = v;
                    end
                    else if (a.address == ADDR_LATCH1 && v == PRG_FORCE_CODE)
                    begin
                        prg_bank = PRG_FORCE_BANK;
                    end
                    else
                    begin
                        sel = adr & WR_DECODE_MASK;
                        case (sel)
                            WR_SEL_L0:
                            begin
                                latch[0] = v;
                                if (!v[7] && a.scanline < LINE_LIMIT)
                                begin
                                    chr_lo = 1'b0;
                                    chr_hi = 1'b1;
                                end
                            end
                            WR_SEL_L1:
                            begin
                                latch[1] = v;
                                if (v == PRG_FORCE_CODE)
                                    prg_bank = PRG_FORCE_BANK;
                            end
                            WR_SEL_L2: latch[2] = v;
                            default:   latch[3] = v;
                        endcase
                        if (sel == WR_SEL_L0 || sel == WR_SEL_L2)
                        begin
                            prg_bank = {latch[2][3:0], latch[0][3:0]};
                            auto_sw  = latch[0][7];
                        end
                    end
                end
            end
            else if (adr >= PRG_BASE && !wr)
            begin
                banks = prg_rom_bytes / PRG_BANK_BYTES;
                if (banks == 0)
                    banks = 1;
                m = (adr - PRG_BASE) + (prg_bank % banks) * PRG_BANK_BYTES;
                if (m < prg_rom_bytes)
                begin
                    r.target      = TGT_PRG;
                    r.mem_address = m[22:0];
                end
            end
        end
        else
        begin
            // Split-screen bank switch late in scanlines 239 and 127
            if (!wr && auto_sw && a.dot > DOT_LIMIT)
            begin
                if (a.scanline == LINE_SPLIT_HI)
                begin
                    chr_lo = 1'b0;
                    chr_hi = 1'b0;
                end
                else if (a.scanline == LINE_SPLIT_LO)
                begin
                    chr_lo = 1'b1;
                    chr_hi = 1'b1;
                end
            end
            if (chr_bytes != 0)
            begin
                banks = chr_bytes / CHR_BANK_BYTES;
                if (banks == 0)
                    banks = 1;
                bank = (adr < PPU_HI_BASE) ? 32'(chr_lo) : 32'(chr_hi);
                m = (adr & PPU_OFS_MASK) + (bank % banks) * CHR_BANK_BYTES;
                if (m < chr_bytes)
                begin
                    r.target      = TGT_CHR;
                    r.mem_address = m[22:0];
                    r.data        = wr ? v : 8'h00;
                    r.mem_write   = wr;
                end
            end
        end
        return r;
    endfunction

    function automatic req_t bus_access(input logic [1:0] cmd, input logic [15:0] address,
                                        input logic [7:0] value, input int unsigned line,
                                        input int unsigned dot);
        req_t a;
        a.cmd         = cmd;
        a.address     = address;
        a.write_value = value;
        a.scanline    = line[8:0];
        a.dot         = dot[8:0];
        return a;
    endfunction

    // Random access, biased toward the register window and the split lines
    function automatic req_t random_access();
        req_t        a;
        int unsigned pick;
        a.cmd         = CMD_CPU_RD;
        a.address     = 16'($urandom);
        a.write_value = 8'($urandom);
        a.scanline    = 9'($urandom_range(0, 261));
        a.dot         = 9'($urandom_range(0, 340));
        pick = $urandom_range(0, 99);
        if (pick < 32)
        begin
            a.cmd = ($urandom_range(0, 2) != 0) ? CMD_CPU_WR : CMD_CPU_RD;
            case ($urandom_range(0, 7))
                0:       a.address = 16'(REG_BASE);
                1:       a.address = ADDR_LATCH1;
                2:       a.address = ADDR_TRIGGER;
                3:       a.address = 16'(REG_BASE + 32'h0200);
                4:       a.address = 16'(REG_BASE + 32'h0300);
                5:       a.address = 16'(REG_BASE + 32'h0500);
                default: a.address = 16'(REG_BASE + $urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: a.write_value = 8'h00;
                3, 4:    a.write_value = PRG_FORCE_CODE;
                5:       a.write_value = 8'(32'h80 | ($urandom & 32'h0F));
                6:       a.write_value = 8'($urandom & 32'h0F);
                default: a.write_value = 8'($urandom);
            endcase
        end
        else if (pick < 46)
        begin
            a.cmd     = ($urandom_range(0, 1) != 0) ? CMD_CPU_WR : CMD_CPU_RD;
            a.address = 16'(RAM_BASE + $urandom_range(0, 8191));
        end
        else if (pick < 64)
        begin
            a.cmd     = ($urandom_range(0, 9) == 0) ? CMD_CPU_WR : CMD_CPU_RD;
            a.address = 16'(PRG_BASE + $urandom_range(0, 32767));
        end
        else if (pick < 68)
        begin
            a.cmd     = ($urandom_range(0, 1) != 0) ? CMD_CPU_WR : CMD_CPU_RD;
            a.address = 16'($urandom_range(0, REG_BASE - 1));
        end
        else
        begin
            a.cmd = ($urandom_range(0, 3) == 0) ? CMD_PPU_WR : CMD_PPU_RD;
            if ($urandom_range(0, 4) != 0)
                a.address = 16'($urandom_range(0, 32'h1FFF));
            case ($urandom_range(0, 4))
                0:       a.scanline = LINE_SPLIT_HI;
                1:       a.scanline = LINE_SPLIT_LO;
                default: ;
            endcase
            if ($urandom_range(0, 1) != 0)
                a.dot = 9'($urandom_range(32'(DOT_LIMIT), 340));
        end
        return a;
    endfunction

    // Offer one access; the predicted result is queued when it is accepted.
    // Valid is only lowered on an idle cycle, never between back-to-back transactions.
    task automatic send_access(input req_t a);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= a;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        mapped_q.push_back(map_access(a));
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
    endtask

    // Size register write; only called with the block idle
    task automatic write_size(input logic [1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[23:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PRG_ROM_SIZE: prg_rom_bytes = value & 32'hFFFFFF;
            CFG_CHR_ROM_SIZE: chr_bytes     = value & 32'h1FFFFF;
            CFG_PRG_RAM_SIZE: ram_bytes     = value & 32'h3FFF;
            default: ;
        endcase
    endtask

    task automatic write_sizes(input int unsigned prg, input int unsigned chr,
                               input int unsigned ram);
        write_size(CFG_PRG_ROM_SIZE, prg);
        write_size(CFG_CHR_ROM_SIZE, chr);
        write_size(CFG_PRG_RAM_SIZE, ram);
    endtask

    // Mapping probe: high program bank, then a low one, across all memories
    task automatic probe_maps();
        send_access(bus_access(CMD_CPU_WR, 16'(REG_BASE), 8'h0F, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'(REG_BASE + 32'h0200), 8'h0F, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h8000, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'hFFFF, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h6063, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'h7FFF, 8'h5A, 0, 0));
        send_access(bus_access(CMD_PPU_RD, 16'h0000, 8'h00, 0, 0));
        send_access(bus_access(CMD_PPU_RD, 16'h1FFF, 8'h00, 0, 0));
        send_access(bus_access(CMD_PPU_WR, 16'h1000, 8'hC3, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'(REG_BASE + 32'h0200), 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'(REG_BASE), 8'h02, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h8123, 8'h00, 0, 0));
    endtask

    // Directed: decode edges, every command, register side effects, auto switch
    task automatic test_directed_accesses();
        tx_idle_pct = 9;
        rx_idle_pct = 53;
        send_access(bus_access(CMD_CPU_RD, 16'h0000, 8'h00, 0, 0));     // below registers
        send_access(bus_access(CMD_CPU_RD, 16'h4FFF, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h5000, 8'h00, 0, 0));     // default read value
        send_access(bus_access(CMD_CPU_RD, 16'h5100, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h5500, 8'h00, 0, 0));     // toggle set
        send_access(bus_access(CMD_CPU_WR, 16'h5000, 8'h85, 200, 0));   // auto switch on
        send_access(bus_access(CMD_CPU_WR, 16'h5200, 8'h12, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'h5300, 8'h40, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'h5100, PRG_FORCE_CODE, 0, 0)); // forced bank only
        send_access(bus_access(CMD_CPU_WR, 16'h5180, PRG_FORCE_CODE, 0, 0)); // latch 1 and force
        send_access(bus_access(CMD_CPU_WR, ADDR_TRIGGER, 8'h33, 0, 0));
        send_access(bus_access(CMD_CPU_WR, ADDR_TRIGGER, 8'h00, 0, 0)); // toggle flips
        send_access(bus_access(CMD_CPU_RD, 16'h5500, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h5DFF, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'h7FFF, 8'hA5, 0, 0));     // top of work RAM
        send_access(bus_access(CMD_CPU_RD, 16'h6000, 8'hFF, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'h8000, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_RD, 16'hFFFF, 8'h00, 0, 0));
        send_access(bus_access(CMD_CPU_WR, 16'h8000, 8'h77, 0, 0));     // ROM write ignored
        send_access(bus_access(CMD_PPU_RD, 16'h0000, 8'h00, 239, 257)); // both banks to 0
        send_access(bus_access(CMD_PPU_RD, 16'h1FFF, 8'h00, 127, 340)); // both banks to 1
        send_access(bus_access(CMD_PPU_RD, 16'h0010, 8'h00, 239, 256)); // dot not past limit
        send_access(bus_access(CMD_CPU_WR, 16'h5000, 8'h01, 100, 0));   // early line: 0 / 1
        send_access(bus_access(CMD_PPU_WR, 16'h1234, 8'hFF, 127, 300));
        send_access(bus_access(CMD_PPU_RD, 16'h0FFF, 8'h00, 239, 300)); // auto switch off
        drain();
    endtask

    // Size registers at the extremes and at odd sizes, so bank wrap and range checks fire
    task automatic test_size_registers();
        write_sizes(0, 0, 0);
        probe_maps();
        drain();
        write_sizes(PRG_ROM_MAX, CHR_ROM_MAX, PRG_RAM_MAX);
        probe_maps();
        drain();
        write_sizes(3 * PRG_BANK_BYTES + 100, 5000, 100);
        probe_maps();
        drain();
        write_sizes(5 * PRG_BANK_BYTES, CHR_BANK_BYTES, 1);
        probe_maps();
        drain();
    endtask

    // One random phase: fresh sizes, then a long stretch of random traffic
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned count);
        int unsigned prg;
        int unsigned chr;
        int unsigned ram;
        case ($urandom_range(0, 3))
            0:       prg = $urandom_range(0, PRG_ROM_MAX);
            1:       prg = $urandom_range(0, 300000);
            default: prg = $urandom_range(1, 8) * PRG_BANK_BYTES;
        endcase
        case ($urandom_range(0, 4))
            0:       chr = 0;
            1:       chr = $urandom_range(0, CHR_ROM_MAX);
            default: chr = $urandom_range(1, 4) * CHR_BANK_BYTES;
        endcase
        ram = ($urandom_range(0, 1) != 0) ? PRG_RAM_MAX : $urandom_range(0, PRG_RAM_MAX);
        write_sizes(prg, chr, ram);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
            send_access(random_access());
        drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the holding register fills and req_ready drops
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(negedge clk);
        hold_cycles = 300;
        repeat (40)
            send_access(random_access());
        drain();
    endtask

    // Receiver side: random ready, forced low during a hold-off
    always @(negedge clk)
        rsp_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rx_idle_pct);

    // Hold-off counter
    always @(posedge clk)
        if (hold_cycles != 0)
            hold_cycles = hold_cycles - 1;

    // Result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (mapped_q.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result tgt=%0d addr=%h data=%h we=%b",
                             $realtime, rsp.target, rsp.mem_address, rsp.data, rsp.mem_write);
            end
            else
            begin
                want = mapped_q.pop_front();
                if (rsp.target !== want.target || rsp.mem_address !== want.mem_address ||
                    rsp.data !== want.data || rsp.mem_write !== want.mem_write)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp tgt=%0d addr=%h data=%h we=%b",
                                  " got tgt=%0d addr=%h data=%h we=%b"}, $realtime,
                                 want.target, want.mem_address, want.data, want.mem_write,
                                 rsp.target, rsp.mem_address, rsp.data, rsp.mem_write);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        // Predictor starts from the reset state of the block
        prg_rom_bytes = PRG_BANK_BYTES;
        chr_bytes     = 8192;
        ram_bytes     = PRG_RAM_MAX;
        foreach (latch[i])
            latch[i] = 8'h00;
        trigger_byte = 8'h00;
        toggle_bit   = 1'b1;
        prg_bank     = 8'h00;
        chr_lo       = 1'b0;
        chr_hi       = 1'b0;
        auto_sw      = 1'b0;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_accesses();
        test_size_registers();
        test_random_traffic(9, 53, 360);
        test_random_traffic(53, 9, 360);
        test_random_traffic(0, 0, 360);
        test_output_stall();

        // Let any stray result show up before the verdict
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0 && mapped_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/cbm_pkg.sv
hdl/cbm_mod.sv
hdl/cartridge_bank_mapper_top.sv
bench/tb.sv
